[rtl/mfh_pkg.sv]
// ----------------------------------------------------------------------------
// MQTT fixed header decoder package
// Shared types, status codes and the flag check for the header decoder.
// ----------------------------------------------------------------------------
package mfh_pkg;

  localparam int unsigned LenW = 28;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StBadFlags = 2'd1,
    StBadLen   = 2'd2
  } status_e;

  localparam logic [3:0] FlagsTwo  = 4'h2;
  localparam logic [3:0] FlagsZero = 4'h0;
  localparam logic [3:0] QosMask   = 4'h6;

  localparam logic [3:0] KindReservedLow  = 4'd0;
  localparam logic [3:0] KindPublish      = 4'd3;
  localparam logic [3:0] KindPubrel       = 4'd6;
  localparam logic [3:0] KindSubscribe    = 4'd8;
  localparam logic [3:0] KindUnsubscribe  = 4'd10;
  localparam logic [3:0] KindReservedHigh = 4'd15;

  typedef struct packed {
    logic            in_len;
    logic [3:0]      kind;
    logic [3:0]      flags;
    logic [LenW-1:0] acc;
    logic [1:0]      cnt;
  } state_t;

  typedef struct packed {
    logic [3:0]      kind;
    logic [3:0]      flags;
    logic [LenW-1:0] length;
    status_e         status;
  } result_t;

  function automatic logic flags_ok(input logic [3:0] kind, input logic [3:0] flags);
    logic ok;
    case (kind)
      KindPubrel, KindSubscribe, KindUnsubscribe: ok = (flags == FlagsTwo);
      KindPublish: ok = ((flags & QosMask) != QosMask);
      KindReservedLow, KindReservedHigh: ok = 1'b1;
      default: ok = (flags == FlagsZero);
    endcase
    return ok;
  endfunction

endpackage

[rtl/mfh_step.sv]
// ----------------------------------------------------------------------------
// MQTT fixed header decoder step
// Combinational update of the header state for one stream byte.
// ----------------------------------------------------------------------------
module mfh_step (
  input  mfh_pkg::state_t  state_i,
  input  logic [7:0]       stream_byte_i,
  output mfh_pkg::state_t  state_o,
  output logic             res_valid_o,
  output mfh_pkg::result_t res_o
);

  logic [mfh_pkg::LenW-1:0] shifted;
  logic [mfh_pkg::LenW-1:0] acc_sum;
  logic [3:0]               new_kind;
  logic [3:0]               new_flags;

  assign new_kind  = stream_byte_i[7:4];
  assign new_flags = stream_byte_i[3:0];

  always_comb begin
    case (state_i.cnt)
      2'd0:    shifted = {21'd0, stream_byte_i[6:0]};
      2'd1:    shifted = {14'd0, stream_byte_i[6:0], 7'd0};
      2'd2:    shifted = {7'd0, stream_byte_i[6:0], 14'd0};
      default: shifted = {stream_byte_i[6:0], 21'd0};
    endcase
  end

  assign acc_sum = state_i.acc + shifted;

  always_comb begin
    state_o     = state_i;
    res_valid_o = 1'b0;
    res_o.kind   = state_i.kind;
    res_o.flags  = state_i.flags;
    res_o.length = '0;
    res_o.status = mfh_pkg::StOk;
    if (!state_i.in_len) begin
      state_o.kind  = new_kind;
      state_o.flags = new_flags;
      res_o.kind    = new_kind;
      res_o.flags   = new_flags;
      if (!mfh_pkg::flags_ok(new_kind, new_flags)) begin
        res_valid_o  = 1'b1;
        res_o.status = mfh_pkg::StBadFlags;
      end else begin
        state_o.in_len = 1'b1;
        state_o.acc    = '0;
        state_o.cnt    = 2'd0;
      end
    end else begin
      state_o.acc = acc_sum;
      if (stream_byte_i[7]) begin
        if (state_i.cnt == 2'd3) begin
          state_o.in_len = 1'b0;
          state_o.cnt    = 2'd0;
          res_valid_o    = 1'b1;
          res_o.status   = mfh_pkg::StBadLen;
        end else begin
          state_o.cnt = state_i.cnt + 2'd1;
        end
      end else begin
        state_o.in_len = 1'b0;
        state_o.cnt    = 2'd0;
        res_valid_o    = 1'b1;
        res_o.length   = acc_sum;
      end
    end
  end

endmodule

[rtl/mfh_out_buf.sv]
// ----------------------------------------------------------------------------
// MQTT fixed header decoder output buffer
// Result register with a skid entry so the input side keeps moving while a
// result waits.
// ----------------------------------------------------------------------------
module mfh_out_buf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             res_valid_i,
  input  mfh_pkg::result_t res_i,
  output logic             full_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output mfh_pkg::result_t out_o
);

  logic             out_valid_q, out_valid_d;
  logic             skid_valid_q, skid_valid_d;
  mfh_pkg::result_t out_q, out_d;
  mfh_pkg::result_t skid_q, skid_d;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (!out_valid_q || !out_stall_i) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = res_valid_i;
        out_d       = res_i;
      end
    end else if (res_valid_i) begin
      skid_valid_d = 1'b1;
      skid_d       = res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held without an output entry");

  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && out_q == $past(out_q)))
    else $error("stalled result changed");

  a_no_res_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> !res_valid_i)
    else $error("result arrived while the skid entry was full");

endmodule

[rtl/mqtt_fixed_header_decoder_core.sv]
// ----------------------------------------------------------------------------
// MQTT fixed header decoder core
// Results: the result of the byte that ends a header (a bad first byte or the last
// remaining length byte) is registered in the output register, or in the skid entry while the output stalls.
// Throughput: one stream byte per cycle unless the full output buffer stalls the
// input; a two-entry output buffer decouples the output stall.
// Reset: asynchronous, active low; clears the header state and the buffer.
// ----------------------------------------------------------------------------
module mqtt_fixed_header_decoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  stream_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  packet_kind_o,
  output logic [3:0]  header_flags_o,
  output logic [27:0] payload_length_o,
  output logic [1:0]  status_o
);

  mfh_pkg::state_t  state_q, state_d, step_state;
  mfh_pkg::result_t step_res, out_res;
  logic             step_valid;
  logic             accept;
  logic             buf_full;

  assign in_stall_o = buf_full;
  assign accept     = in_valid_i && !buf_full;

  mfh_step u_step (
    .state_i       (state_q),
    .stream_byte_i (stream_byte_i),
    .state_o       (step_state),
    .res_valid_o   (step_valid),
    .res_o         (step_res)
  );

  assign state_d = accept ? step_state : state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  mfh_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (accept && step_valid),
    .res_i       (step_res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_res)
  );

  assign packet_kind_o    = out_res.kind;
  assign header_flags_o   = out_res.flags;
  assign payload_length_o = out_res.length;
  assign status_o         = out_res.status;

  a_cnt_in_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.cnt != 2'd0) |-> state_q.in_len)
    else $error("length byte count set outside the length phase");

  a_err_zero_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != mfh_pkg::StOk) |-> (payload_length_o == '0))
    else $error("error result carries a nonzero length");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == mfh_pkg::StOk || status_o == mfh_pkg::StBadFlags ||
                     status_o == mfh_pkg::StBadLen))
    else $error("undefined status code on output");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> (state_q == $past(state_q)))
    else $error("header state changed without a transfer");

endmodule

[dv/mfh_header_checker.sv]
// ----------------------------------------------------------------------------
// MQTT fixed header decoder checker
// Watches both channels of the header decoder. Each accepted stream byte runs
// through a local decoder that predicts the header results, and each accepted
// output transfer is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module mfh_header_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  stream_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [3:0]  packet_kind_i,
  input  logic [3:0]  header_flags_i,
  input  logic [27:0] payload_length_i,
  input  logic [1:0]  status_i,
  output int unsigned errors_o,
  output int unsigned pending_o,
  output int unsigned ok_seen_o,
  output int unsigned bad_flags_seen_o,
  output int unsigned bad_len_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LenW           = mfh_pkg::LenW;
  localparam logic [1:0]  LastLenByte    = 2'd3;
  localparam int unsigned BitsPerLenByte = 7;

  logic             hdr_in_len;
  logic [3:0]       hdr_kind;
  logic [3:0]       hdr_flags;
  logic [LenW-1:0]  len_acc;
  logic [1:0]       len_cnt;
  mfh_pkg::result_t header_q[$];

  int unsigned errors;
  int unsigned ok_seen;
  int unsigned bad_flags_seen;
  int unsigned bad_len_seen;

  function automatic logic flags_legal(input logic [3:0] kind, input logic [3:0] flags);
    logic legal;
    case (kind)
      mfh_pkg::KindPubrel, mfh_pkg::KindSubscribe,
      mfh_pkg::KindUnsubscribe: legal = (flags == mfh_pkg::FlagsTwo);
      mfh_pkg::KindPublish: legal = ((flags & mfh_pkg::QosMask) != mfh_pkg::QosMask);
      mfh_pkg::KindReservedLow, mfh_pkg::KindReservedHigh: legal = 1'b1;
      default: legal = (flags == mfh_pkg::FlagsZero);
    endcase
    return legal;
  endfunction

  task automatic push_header(input logic [LenW-1:0] length, input mfh_pkg::status_e status);
    mfh_pkg::result_t res;
    res.kind   = hdr_kind;
    res.flags  = hdr_flags;
    res.length = length;
    res.status = status;
    header_q.insert(header_q.size(), res);
  endtask

  task automatic decode_byte(input logic [7:0] b);
    logic [LenW-1:0] chunk;
    if (!hdr_in_len) begin
      hdr_kind  = b[7:4];
      hdr_flags = b[3:0];
      if (!flags_legal(hdr_kind, hdr_flags)) begin
        push_header('0, mfh_pkg::StBadFlags);
      end else begin
        hdr_in_len = 1'b1;
        len_acc    = '0;
        len_cnt    = '0;
      end
    end else begin
      chunk   = LenW'(b[6:0]) << (BitsPerLenByte * len_cnt);
      len_acc = len_acc + chunk;
      if (b[7]) begin
        if (len_cnt == LastLenByte) begin
          hdr_in_len = 1'b0;
          len_cnt    = '0;
          push_header('0, mfh_pkg::StBadLen);
        end else begin
          len_cnt = len_cnt + 2'd1;
        end
      end else begin
        hdr_in_len = 1'b0;
        len_cnt    = '0;
        push_header(len_acc, mfh_pkg::StOk);
      end
    end
  endtask

  task automatic check_header();
    mfh_pkg::result_t exp;
    if (header_q.size() == 0) begin
      $error("unexpected output transfer: kind %0d flags %0d length %0d status %0d",
             packet_kind_i, header_flags_i, payload_length_i, status_i);
      errors++;
    end else begin
      exp = header_q.pop_front();
      if (packet_kind_i !== exp.kind) begin
        $error("packet_kind: expected %0d, actual %0d", exp.kind, packet_kind_i);
        errors++;
      end
      if (header_flags_i !== exp.flags) begin
        $error("header_flags: expected %0d, actual %0d", exp.flags, header_flags_i);
        errors++;
      end
      if (payload_length_i !== exp.length) begin
        $error("payload_length: expected %0d, actual %0d", exp.length, payload_length_i);
        errors++;
      end
      if (status_i !== exp.status) begin
        $error("status: expected %0d, actual %0d", exp.status, status_i);
        errors++;
      end
      case (exp.status)
        mfh_pkg::StOk: ok_seen++;
        mfh_pkg::StBadFlags: bad_flags_seen++;
        default: bad_len_seen++;
      endcase
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_in_len = 1'b0;
      hdr_kind   = '0;
      hdr_flags  = '0;
      len_acc    = '0;
      len_cnt    = '0;
      header_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) check_header();
      if (in_valid_i && !in_stall_i) decode_byte(stream_byte_i);
    end
    errors_o         <= errors;
    pending_o        <= header_q.size();
    ok_seen_o        <= ok_seen;
    bad_flags_seen_o <= bad_flags_seen;
    bad_len_seen_o   <= bad_len_seen;
  end

  initial begin
    errors         = 0;
    ok_seen        = 0;
    bad_flags_seen = 0;
    bad_len_seen   = 0;
  end

endmodule

[dv/mqtt_fixed_header_decoder_core_tb.sv]
// ----------------------------------------------------------------------------
// MQTT fixed header decoder testbench
// Feeds the decoder a byte stream of directed corner headers followed by mostly
// well-formed random headers mixed with noise, bad flags and malformed lengths.
// Input bursts and output stalls vary at random; the checker scores results.
// ----------------------------------------------------------------------------
module mqtt_fixed_header_decoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ItemCount  = 1900;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainWait  = 8;

  typedef enum logic [1:0] {
    StallNone,
    StallLight,
    StallHeavy,
    StallPeriodic
  } stall_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  stream_byte_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [3:0]  packet_kind_o;
  logic [3:0]  header_flags_o;
  logic [27:0] payload_length_o;
  logic [1:0]  status_o;

  int unsigned errors;
  int unsigned pending;
  int unsigned ok_seen;
  int unsigned bad_flags_seen;
  int unsigned bad_len_seen;

  int unsigned cycle_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned burst_left = 0;
  int unsigned stall_left = 0;
  stall_mode_e stall_mode = StallNone;

  mqtt_fixed_header_decoder_core DUT (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .stream_byte_i,
    .out_valid_o,
    .out_stall_i,
    .packet_kind_o,
    .header_flags_o,
    .payload_length_o,
    .status_o
  );

  mfh_header_checker u_checker (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_i       (in_stall_o),
    .stream_byte_i,
    .out_valid_i      (out_valid_o),
    .out_stall_i,
    .packet_kind_i    (packet_kind_o),
    .header_flags_i   (header_flags_o),
    .payload_length_i (payload_length_o),
    .status_i         (status_o),
    .errors_o         (errors),
    .pending_o        (pending),
    .ok_seen_o        (ok_seen),
    .bad_flags_seen_o (bad_flags_seen),
    .bad_len_seen_o   (bad_len_seen)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Run stopped after %0d cycles with %0d results outstanding.",
               cycle_count, pending);
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
      stall_left <= $urandom_range(8, 150);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      StallNone: out_stall_i <= 1'b0;
      StallLight: out_stall_i <= ($urandom_range(0, 3) == 0);
      StallHeavy: out_stall_i <= ($urandom_range(0, 3) != 0);
      default: out_stall_i <= (stall_left % 3 == 0);
    endcase
  end

  task automatic put_byte(input logic [7:0] b);
    if (burst_left == 0) begin
      in_valid_i    <= 1'b0;
      stream_byte_i <= 8'($urandom);
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    in_valid_i    <= 1'b1;
    stream_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    burst_left--;
    bytes_sent++;
  endtask

  function automatic logic [3:0] pick_flags(input logic [3:0] kind);
    logic [3:0] flags;
    case (kind)
      mfh_pkg::KindPubrel, mfh_pkg::KindSubscribe,
      mfh_pkg::KindUnsubscribe: flags = mfh_pkg::FlagsTwo;
      mfh_pkg::KindPublish: begin
        do flags = 4'($urandom); while ((flags & mfh_pkg::QosMask) == mfh_pkg::QosMask);
      end
      default: flags = ($urandom_range(0, 3) != 0) ? mfh_pkg::FlagsZero : 4'($urandom);
    endcase
    return flags;
  endfunction

  function automatic logic [6:0] pick_len_bits();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 2) return 7'h7f;
    if (r == 2) return 7'h00;
    return 7'($urandom);
  endfunction

  task automatic send_random_header();
    int unsigned choice;
    int unsigned r;
    int unsigned nlen;
    logic        malformed;
    logic [3:0]  kind;
    logic [3:0]  flags;
    choice = $urandom_range(0, 99);
    if (choice < 8) begin
      put_byte(8'($urandom));
    end else begin
      kind  = 4'($urandom);
      flags = (choice < 18) ? 4'($urandom) : pick_flags(kind);
      put_byte({kind, flags});
      r         = $urandom_range(0, 99);
      nlen      = (r < 40) ? 1 : (r < 65) ? 2 : (r < 80) ? 3 : 4;
      malformed = ($urandom_range(0, 9) == 0);
      if (malformed) nlen = 4;
      for (int unsigned i = 0; i < nlen; i++) begin
        put_byte({malformed || (i + 1 < nlen), pick_len_bits()});
      end
    end
  endtask

  initial begin
    logic [7:0] directed[$];
    directed = '{
      8'h30, 8'h00,
      8'h36,
      8'h62, 8'h7f,
      8'h60,
      8'h82, 8'hff, 8'hff, 8'hff, 8'h7f,
      8'ha2, 8'h80, 8'h80, 8'h80, 8'h80,
      8'h0f, 8'h01,
      8'hff, 8'h80, 8'h01,
      8'hc0, 8'h00,
      8'he1
    };
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) put_byte(directed[i]);
    while (bytes_sent < ItemCount) send_random_header();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    $display("Sent %0d stream bytes over %0d cycles under varied input gaps and output stalls.",
             bytes_sent, cycle_count);
    $display("Checked headers: %0d good, %0d with bad flags, %0d with malformed length.",
             ok_seen, bad_flags_seen, bad_len_seen);
    if (out_valid_o) begin
      $error("result still offered after all predicted results were checked");
    end
    if (errors == 0 && !out_valid_o) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
